@@ rtl/core/bilt_pkg.sv @@
// Shared types and constants for the bounded integer list table.
package bilt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int WORD_W   = 32;
   localparam int FPOS_W   = 5;

   // Opcodes five to seven are unused and fall to the default arms.
   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_GET    = 3'd1,
      OP_SET    = 3'd2,
      OP_SEARCH = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] word_out;
      logic              found;
      logic [FPOS_W-1:0] found_position;
      logic [CNT_W-1:0]  entry_count;
      logic              is_empty;
   } result_type;

endpackage

@@ rtl/core/bounded_int_list_table.sv @@
// Top level of the bounded integer list table: ports, store, sequencer and output register.
//
//   Channel  Direction  Carries
//   req_     in         one request word: opcode in tuser, position and word_in in tdata
//   rsp_     out        one result word per request: status, read word, search hit, count
//
// A request is taken only while the sequencer is idle. Append, set, clear and unused
// opcodes pass through the execute state to the done state, where the result is ready to
// hand over; a get in range adds a read state between them, and a search a scan step for
// each entry compared, since the single read port of the entry store yields one entry per
// cycle. The sequencer returns to idle in the cycle after passing its result on, so the
// next request can be taken meanwhile even if the output register is still stalled.
// Reset empties the list and drops any pending result; the entry store itself is not
// cleared because only entries below the count are ever read.
module bounded_int_list_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position [3:0], word_in [35:4], zero [39:36]
   input  logic [2:0]  req_tuser,  // opcode [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // status [1:0], word_out [33:2], found [34],
                                   // found_position [39:35], entry_count [44:40],
                                   // is_empty [45], zero [47:46]
);
   import bilt_pkg::*;

   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rdata;
   logic              res_valid;
   logic              res_ready;
   result_type        result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;

   bilt_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   bilt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_pos   (req_tdata[3:0]),
      .req_word  (req_tdata[35:4]),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   // The output register takes a new result when it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, result.is_empty, result.entry_count,
                         result.found_position, result.found, result.word_out,
                         result.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/bilt_ram.sv @@
// Entry store: one write port and one read port with registered read data.
module bilt_ram (
   input  logic                        clock,
   input  bilt_pkg::mem_req_type       mem_req,
   output logic [bilt_pkg::WORD_W-1:0] rd_data
);
   import bilt_pkg::*;

   logic [WORD_W-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[mem_req.rd_addr];
   end

endmodule

@@ rtl/core/bilt_engine.sv @@
// Request sequencer: decodes one request, drives the entry store and builds the result.
module bilt_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_op,
   input  logic [bilt_pkg::IDX_W-1:0]  req_pos,
   input  logic [bilt_pkg::WORD_W-1:0] req_word,
   output bilt_pkg::mem_req_type       mem_req,
   input  logic [bilt_pkg::WORD_W-1:0] mem_rdata,
   output logic                        res_valid,
   input  logic                        res_ready,
   output bilt_pkg::result_type        result
);
   import bilt_pkg::*;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] rdword_ff, rdword_in;
   logic              found_ff, found_in;
   logic [FPOS_W-1:0] fpos_ff, fpos_in;

   logic in_range;
   logic is_full;
   logic hit;
   logic last_entry;

   assign in_range   = {1'b0, pos_ff} < count_ff;
   assign is_full    = count_ff >= CNT_W'(CAPACITY);
   assign hit        = (mem_rdata == word_ff);
   assign last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_GET:    state_in = in_range ? S_READ : S_DONE;
               OP_SEARCH: state_in = (count_ff != '0) ? S_SCAN : S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_READ: state_in = S_DONE;
         S_SCAN: begin
            if (hit || last_entry) state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshake and result outputs.
   always_comb begin
      req_ready             = (state_ff == S_IDLE);
      res_valid             = (state_ff == S_DONE);
      result.status         = status_ff;
      result.word_out       = rdword_ff;
      result.found          = found_ff;
      result.found_position = fpos_ff;
      result.entry_count    = count_ff;
      result.is_empty       = (count_ff == '0);
   end

   // Datapath and store accesses.
   always_comb begin
      op_in           = op_ff;
      pos_in          = pos_ff;
      word_in         = word_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      status_in       = status_ff;
      rdword_in       = rdword_ff;
      found_in        = found_ff;
      fpos_in         = fpos_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = pos_ff;
      mem_req.wr_data = word_ff;
      mem_req.rd_addr = pos_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               pos_in    = req_pos;
               word_in   = req_word;
               status_in = ST_OK;
               rdword_in = '1;
               found_in  = 1'b0;
               fpos_in   = '1;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_APPEND: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = count_ff[IDX_W-1:0];
                     count_in        = count_ff + CNT_W'(1);
                  end
               end
               OP_GET: begin
                  if (!in_range) status_in = ST_RANGE;
               end
               OP_SET: begin
                  if (in_range) begin
                     mem_req.wr_en = 1'b1;
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               OP_SEARCH: begin
                  mem_req.rd_addr = '0;
                  idx_in          = '0;
               end
               OP_CLEAR: count_in = '0;
               default: ;
            endcase
         end
         S_READ: rdword_in = mem_rdata;
         S_SCAN: begin
            // Compare the entry read last cycle while fetching the next one.
            mem_req.rd_addr = idx_ff + IDX_W'(1);
            idx_in          = idx_ff + IDX_W'(1);
            if (hit) begin
               found_in = 1'b1;
               fpos_in  = {1'b0, idx_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      word_ff   <= word_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rdword_ff <= rdword_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
   end

endmodule
